// ===== src/aoc_pkg.sv =====
// Package for the AES OFB cipher core: types, commands, constants and AES round functions.
// Used by aoc_ctrl, aoc_datapath and the top level; depends on nothing.
`default_nettype none
package aoc_pkg;

  localparam int unsigned RoundKeySlots = 15;
  localparam int unsigned SlotW = 4;
  localparam int unsigned BlockW = 128;

  typedef enum logic [1:0] {
    ACT_KEY  = 2'd0,
    ACT_IV   = 2'd1,
    ACT_DATA = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef struct packed {
    logic key_we;
    logic iv_we;
    logic start;
    logic round_step;
    logic final_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [SlotW-1:0] round_cnt;
  } dp_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the AES state sits at bits 127-8i down to 120-8i.
  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    int unsigned src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = ((c + r) % 4) * 4 + r;
        t[127-8*(c*4+r) -: 8] = sbox(s[127-8*src -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/aoc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Stands alone; used for the round-key store.
`default_nettype none
module aoc_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 15
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/aoc_datapath.sv =====
// Datapath of the AES OFB core: key RAM, feedback and state registers, one round per cycle.
// Depends on aoc_pkg and aoc_ram.
`default_nettype none
module aoc_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire aoc_pkg::dp_cmd_t          cmd_i,
  output aoc_pkg::dp_stat_t              stat_o,
  input  wire logic [3:0]                slot_i,
  input  wire logic [127:0]              blk_i,
  input  wire logic                      last_i,
  output logic      [127:0]              result_o,
  output logic                           result_last_o
);
  import aoc_pkg::*;

  logic [BlockW-1:0] fb_q, fb_d, st_q, st_d, rk;
  logic [BlockW-1:0] data_q, res_q;
  logic              last_q, res_last_q;
  logic [SlotW-1:0]  cnt_q, cnt_d;

  // Round-key reads are addressed with the next count, cnt_d; cnt_q is the slot now at rk.
  aoc_ram #(.Width(BlockW), .Depth(RoundKeySlots)) u_keys (
    .clk_i  (clk_i),
    .we_i   (cmd_i.key_we),
    .waddr_i(slot_i),
    .wdata_i(blk_i),
    .raddr_i(cnt_d),
    .rdata_o(rk)
  );

  always_comb begin
    cnt_d = cnt_q;
    st_d  = st_q;
    fb_d  = fb_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.round_step) begin
      st_d  = (cnt_q == '0) ? (fb_q ^ rk) : (mix_columns(sub_shift(st_q)) ^ rk);
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.final_step) begin
      fb_d = sub_shift(st_q) ^ rk;
    end
    if (cmd_i.iv_we) begin
      fb_d = blk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q  <= '0;
      cnt_q <= '0;
    end else begin
      fb_q  <= fb_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (cmd_i.start) begin
      data_q <= blk_i;
      last_q <= last_i;
    end
    if (cmd_i.out_load) begin
      res_q      <= data_q ^ fb_q;
      res_last_q <= last_q;
    end
  end

  assign stat_o.round_cnt = cnt_q;
  assign result_o         = res_q;
  assign result_last_o    = res_last_q;
endmodule
`default_nettype wire

// ===== src/aoc_ctrl.sv =====
// Controller of the AES OFB core: handshakes, round sequencing and the output register valid.
// Depends on aoc_pkg.
`default_nettype none
module aoc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [3:0]        slot_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_data_i,
  output aoc_pkg::dp_cmd_t       cmd_o,
  input  wire aoc_pkg::dp_stat_t stat_i
);
  import aoc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FINAL = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic [1:0] mode_q;
  logic [3:0] rounds;
  logic       acc;

  always_comb begin
    unique case (mode_q)
      2'd0:    rounds = 4'd10;
      2'd1:    rounds = 4'd12;
      default: rounds = 4'd14;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (action_e'(action_i))
            ACT_KEY:  cmd_o.key_we = ({1'b0, slot_i} < 5'(RoundKeySlots));
            ACT_IV:   cmd_o.iv_we = 1'b1;
            ACT_DATA: begin
              cmd_o.start = 1'b1;
              state_d     = S_ROUND;
            end
            default: ;
          endcase
        end
      end
      S_ROUND: begin
        cmd_o.round_step = 1'b1;
        if (stat_i.round_cnt == rounds - 4'd1) state_d = S_FINAL;
      end
      S_FINAL: begin
        cmd_o.final_step = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_d) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      mode_q   <= 2'd0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) mode_q <= cfg_data_i;
    end
  end
endmodule
`default_nettype wire

// ===== src/aes_ofb_crypt_core.sv =====
// Top level of the AES OFB cipher core.
// Depends on aoc_pkg, aoc_ctrl and aoc_datapath.
`default_nettype none
// A data block holds the input side off from its acceptance until its result is loaded into
// the output register. This is set by the single shared AES round unit, which runs one round
// per cycle, plus a whitening step and an output step. Key and IV loads are written at
// acceptance and leave the core idle. A finished result waits in an output register while
// the next item is taken. If that register is still full, the block waits in its last step
// until the register is free. Round keys must be loaded for slots 0 to the round count before
// any data block.
module aes_ofb_crypt_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // key_slot[3:0], data_high[67:4], data_low[131:68]
  input  wire logic [1:0]   s_axis_tuser,  // action[1:0]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,  // result_high[63:0], result_low[127:64]
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_data_i     // key_size_mode[1:0]
);
  import aoc_pkg::*;

  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic [127:0] res;

  aoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .slot_i     (s_axis_tdata[3:0]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  aoc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .slot_i       (s_axis_tdata[3:0]),
    .blk_i        ({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
    .last_i       (s_axis_tlast),
    .result_o     (res),
    .result_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for aes_ofb_crypt_core: key, IV and data items with random gaps.
// It predicts each keystream block with its own AES encryptor. Depends on aoc_pkg.
module tb_top;
  import aoc_pkg::*;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } ofb_block_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [135:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i, cfg_ready_o;
  logic [1:0]   cfg_data_i;

  logic [127:0] round_keys [RoundKeySlots];
  logic [127:0] feedback;
  logic [1:0]   key_size;
  ofb_block_t   pending_blocks [$];
  int           errors, cycles;
  bit           gaps_on;

  logic [7:0] sbox_tbl [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  aes_ofb_crypt_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] gf_double(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(logic [127:0] blk, int rounds);
    logic [127:0] s, t;
    logic [7:0] b0, b1, b2, b3, x;
    s = blk ^ round_keys[0];
    for (int r = 1; r <= rounds; r++) begin
      for (int col = 0; col < 4; col++)
        for (int row = 0; row < 4; row++)
          t[127-8*(4*col+row) -: 8] = sbox_tbl[byte_at(s, 4*((col+row)%4)+row)];
      s = t;
      if (r < rounds) begin
        for (int col = 0; col < 4; col++) begin
          b0 = byte_at(t, 4*col);   b1 = byte_at(t, 4*col+1);
          b2 = byte_at(t, 4*col+2); b3 = byte_at(t, 4*col+3);
          x = b0 ^ b1 ^ b2 ^ b3;
          s[127-32*col -: 8] = b0 ^ x ^ gf_double(b0 ^ b1);
          s[119-32*col -: 8] = b1 ^ x ^ gf_double(b1 ^ b2);
          s[111-32*col -: 8] = b2 ^ x ^ gf_double(b2 ^ b3);
          s[103-32*col -: 8] = b3 ^ x ^ gf_double(b3 ^ b0);
        end
      end
      s = s ^ round_keys[r];
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 19);
    if (p < 12) return 0;
    if (p < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(action_e act, logic [3:0] slot, logic [63:0] hi, logic [63:0] lo,
                           logic last);
    int gap;
    logic [127:0] ks;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {4'b0, lo, hi, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    case (act)
      ACT_KEY:  if (slot < RoundKeySlots) round_keys[slot] = {hi, lo};
      ACT_IV:   feedback = {hi, lo};
      ACT_DATA: begin
        ks = aes_encrypt(feedback, key_size == 2'd0 ? 10 : key_size == 2'd1 ? 12 : 14);
        feedback = ks;
        pending_blocks.push_back('{hi ^ ks[127:64], lo ^ ks[63:0], last});
      end
      default: ;
    endcase
  endtask

  task automatic end_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_key_size(logic [1:0] mode);
    end_stream();
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_size = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_key_loading();
    for (int i = 0; i < RoundKeySlots; i++)
      send_item(ACT_KEY, 4'(i), rand64(), rand64(), 1'b0);
    // Slot 15 is out of range and the unused action must change nothing.
    send_item(ACT_KEY, 4'd15, '1, '1, 1'b1);
    send_item(ACT_NONE, 4'd15, '1, '1, 1'b1);
  endtask

  task automatic test_directed_blocks();
    send_item(ACT_IV, 4'd0, '0, '0, 1'b0);
    send_item(ACT_DATA, 4'd0, '0, '0, 1'b0);
    send_item(ACT_DATA, 4'd0, '1, '1, 1'b1);
    send_item(ACT_KEY, 4'd0, '1, '1, 1'b0);
    send_item(ACT_KEY, 4'd14, '0, '0, 1'b0);
    send_item(ACT_IV, 4'd0, '1, '1, 1'b1);
    send_item(ACT_DATA, 4'd0, '1, '0, 1'b0);
    for (int m = 1; m < 4; m++) begin
      set_key_size(2'(m));
      send_item(ACT_DATA, 4'd0, '0, '1, 1'b1);
      send_item(ACT_DATA, 4'd0, rand64(), rand64(), 1'b0);
    end
  endtask

  task automatic test_random_stream();
    int p;
    for (int phase = 0; phase < 6; phase++) begin
      set_key_size(phase == 5 ? 2'd0 : 2'($urandom_range(0, 3)));
      gaps_on = (phase != 2);
      send_item(ACT_IV, 4'd0, rand64(), rand64(), 1'($urandom));
      for (int n = 0; n < 85; n++) begin
        p = $urandom_range(0, 19);
        if (p < 14)
          send_item(ACT_DATA, 4'($urandom), rand64(), rand64(), 1'($urandom_range(0, 3) == 0));
        else if (p < 16)
          send_item(ACT_IV, 4'($urandom), rand64(), rand64(), 1'($urandom));
        else if (p < 19)
          send_item(ACT_KEY, 4'($urandom), rand64(), rand64(), 1'($urandom));
        else
          send_item(ACT_NONE, 4'($urandom), rand64(), rand64(), 1'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_KEY;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    feedback = '0;
    key_size = '0;
    errors = 0;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_key_loading();
    test_directed_blocks();
    test_random_stream();
    end_stream();
    drain();
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      @(negedge clk_i);
      m_axis_tready <= (n == 0);
      repeat (n) @(negedge clk_i);
      if (n > 0) m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    ofb_block_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected item %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pending_blocks.pop_front();
        if (m_axis_tdata[63:0] !== want.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, want.hi, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[127:64] !== want.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, want.lo,
                   m_axis_tdata[127:64]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: result_last expected %b actual %b", $time, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 600000) begin
      $display("tb_top failed");
      $finish;
    end
  end
endmodule
